[rtl/tdr_pkg.sv]
// shared constants, codes and queue entry type for the dfa recognizer
`timescale 1ns / 1ps

package tdr_pkg;

  // default automaton size
  localparam int NUM_STATES_DEF  = 64;
  localparam int NUM_LETTERS_DEF = 16;

  // field widths
  localparam int CMD_W     = 3;
  localparam int STATE_W   = 6;
  localparam int LETTER_W  = 4;
  localparam int BYTE_W    = 8;
  localparam int VERDICT_W = 2;

  localparam int BYTE_VALUES = 256;

  // request commands
  localparam logic [CMD_W-1:0] CMD_LOAD_TRANS  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_LETTER = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_ACCEPT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SYMBOL      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_END_WORD    = 3'd4;

  // operations handed from front to back
  localparam logic [1:0] OP_TRANS  = 2'd0;
  localparam logic [1:0] OP_ACCEPT = 2'd1;
  localparam logic [1:0] OP_SYMBOL = 2'd2;
  localparam logic [1:0] OP_END    = 2'd3;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_REJECT   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_CHAR = 2'd2;

  // queue between front and back, power of two
  localparam int QUEUE_DEPTH = 4;

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_START_STATE = 1'b0;

  typedef struct packed {
    logic [1:0]          op;
    logic                sym_ok;
    logic [STATE_W-1:0]  state_sel;
    logic [LETTER_W-1:0] letter;
    logic [STATE_W-1:0]  target_state;
    logic                target_valid;
    logic                accept_flag;
    logic [BYTE_W-1:0]   char_code;
  } q_entry_t;

  typedef struct packed {
    logic               wr;
    logic [STATE_W-1:0] wr_value;
    logic [STATE_W-1:0] start;
  } cfg_t;

endpackage

[rtl/tdr_front.sv]
// front end: takes requests, maps bytes to letters, filters loads
`timescale 1ns / 1ps

module tdr_front #(
  parameter int NUM_STATES  = tdr_pkg::NUM_STATES_DEF,
  parameter int NUM_LETTERS = tdr_pkg::NUM_LETTERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tdr_pkg::CMD_W-1:0]    command,
  input  logic [tdr_pkg::STATE_W-1:0]  state_sel,
  input  logic [tdr_pkg::LETTER_W-1:0] letter_sel,
  input  logic [tdr_pkg::STATE_W-1:0]  target_state,
  input  logic                         target_valid,
  input  logic                         accept_flag,
  input  logic [tdr_pkg::BYTE_W-1:0]   char_code,
  input  logic                         clearing,
  output logic                         q_push,
  output tdr_pkg::q_entry_t            q_entry,
  input  logic                         q_ready
);
  import tdr_pkg::*;

  logic [LETTER_W-1:0]    lmem [BYTE_VALUES];
  logic [BYTE_VALUES-1:0] lvalid;
  logic [LETTER_W-1:0]    lm_rdata;
  logic                   f_valid;
  q_entry_t               f_entry;
  logic                   accept;
  logic                   keep;
  logic                   letter_ok;
  logic                   state_ok;
  logic                   lm_we;
  logic [1:0]             op_next;

  assign in_ready  = !clearing && (!f_valid || q_ready);
  assign accept    = in_valid && in_ready;
  assign letter_ok = 32'(letter_sel) < 32'(NUM_LETTERS);
  assign state_ok  = 32'(state_sel) < 32'(NUM_STATES);
  // first letter given for a byte wins
  assign lm_we = accept && (command == CMD_LOAD_LETTER) && letter_ok && !lvalid[char_code];

  always_comb begin
    keep    = 1'b0;
    op_next = OP_TRANS;
    case (command)
      CMD_LOAD_TRANS: begin
        keep    = state_ok && letter_ok;
        op_next = OP_TRANS;
      end
      CMD_SET_ACCEPT: begin
        keep    = state_ok;
        op_next = OP_ACCEPT;
      end
      CMD_SYMBOL: begin
        keep    = 1'b1;
        op_next = OP_SYMBOL;
      end
      CMD_END_WORD: begin
        keep    = 1'b1;
        op_next = OP_END;
      end
      default: begin
        keep    = 1'b0;
        op_next = OP_TRANS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
      lvalid  <= '0;
    end else begin
      if (accept) begin
        f_valid <= keep;
      end else if (q_push) begin
        f_valid <= 1'b0;
      end
      if (lm_we) begin
        lvalid[char_code] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_entry.op           <= op_next;
      f_entry.sym_ok       <= lvalid[char_code];
      f_entry.state_sel    <= state_sel;
      f_entry.letter       <= letter_sel;
      f_entry.target_state <= target_state;
      f_entry.target_valid <= target_valid;
      f_entry.accept_flag  <= accept_flag;
      f_entry.char_code    <= char_code;
    end
  end

  // letter map, read data held while the front stalls
  always_ff @(posedge clk) begin
    if (lm_we) begin
      lmem[char_code] <= letter_sel;
    end
    if (accept) begin
      lm_rdata <= lmem[char_code];
    end
  end

  assign q_push = f_valid && q_ready;

  always_comb begin
    q_entry = f_entry;
    if (f_entry.op == OP_SYMBOL) begin
      q_entry.letter = lm_rdata;
    end
  end

endmodule

[rtl/tdr_queue.sv]
// small fifo of classified operations between front and back
`timescale 1ns / 1ps

module tdr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tdr_pkg::q_entry_t push_entry,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output tdr_pkg::q_entry_t pop_entry
);
  import tdr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rd_ptr];

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/tdr_back.sv]
// back end: transition table, accepting map, word state and verdict
`timescale 1ns / 1ps

module tdr_back #(
  parameter int NUM_STATES  = tdr_pkg::NUM_STATES_DEF,
  parameter int NUM_LETTERS = tdr_pkg::NUM_LETTERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tdr_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  tdr_pkg::q_entry_t             q_entry,
  output logic                          q_pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tdr_pkg::VERDICT_W-1:0] verdict,
  output logic [tdr_pkg::BYTE_W-1:0]    bad_char,
  output logic [tdr_pkg::STATE_W-1:0]   final_state
);
  import tdr_pkg::*;

  localparam int TR_DEPTH = NUM_STATES * NUM_LETTERS;
  localparam int TR_AW    = $clog2(TR_DEPTH);
  localparam int AC_AW    = $clog2(NUM_STATES);
  localparam int TR_W     = STATE_W + 1;

  localparam logic [1:0] BK_CLEAR   = 2'd0;
  localparam logic [1:0] BK_IDLE    = 2'd1;
  localparam logic [1:0] BK_STEP    = 2'd2;
  localparam logic [1:0] BK_VERDICT = 2'd3;

  logic [1:0]          state;
  logic [TR_AW-1:0]    clr_cnt;
  logic [STATE_W-1:0]  cur;
  logic                failed;
  logic [BYTE_W-1:0]   fail_byte;

  logic [TR_W-1:0]     tr_mem [TR_DEPTH];
  logic [TR_W-1:0]     tr_rdata;
  logic                acc_mem [NUM_STATES];
  logic                acc_rdata;

  logic                take;
  logic                cur_ok;
  logic                tr_we;
  logic [TR_AW-1:0]    tr_waddr;
  logic [TR_W-1:0]     tr_wdata;
  logic                tr_re;
  logic [TR_AW-1:0]    tr_raddr;
  logic                acc_we;
  logic [AC_AW-1:0]    acc_waddr;
  logic                acc_wdata;
  logic                acc_re;
  logic [AC_AW-1:0]    acc_raddr;

  function automatic logic [TR_AW-1:0] tr_addr(input logic [STATE_W-1:0] s,
                                                input logic [LETTER_W-1:0] l);
    logic [TR_AW+STATE_W-1:0] prod;
    prod = (TR_AW + STATE_W)'(s) * (TR_AW + STATE_W)'(NUM_LETTERS);
    return TR_AW'(prod[TR_AW-1:0] + TR_AW'(l));
  endfunction

  assign clearing = state == BK_CLEAR;
  assign cur_ok   = 32'(cur) < 32'(NUM_STATES);
  assign take     = q_valid && (state == BK_IDLE) &&
                    ((q_entry.op != OP_END) || !out_valid || out_ready);
  assign q_pop    = take;
  assign tr_raddr = tr_addr(cur, q_entry.letter);
  assign acc_raddr = AC_AW'(cur);

  always_comb begin
    tr_we     = 1'b0;
    tr_waddr  = clr_cnt;
    tr_wdata  = '0;
    tr_re     = 1'b0;
    acc_we    = 1'b0;
    acc_waddr = clr_cnt[AC_AW-1:0];
    acc_wdata = 1'b0;
    acc_re    = 1'b0;
    if (state == BK_CLEAR) begin
      tr_we  = 1'b1;
      acc_we = 32'(clr_cnt) < 32'(NUM_STATES);
    end else if (take) begin
      case (q_entry.op)
        OP_TRANS: begin
          tr_we    = 1'b1;
          tr_waddr = tr_addr(q_entry.state_sel, q_entry.letter);
          tr_wdata = q_entry.target_valid ? {1'b1, q_entry.target_state} : '0;
        end
        OP_ACCEPT: begin
          acc_we    = 1'b1;
          acc_waddr = AC_AW'(q_entry.state_sel);
          acc_wdata = q_entry.accept_flag;
        end
        OP_SYMBOL: begin
          tr_re = !failed && q_entry.sym_ok && cur_ok;
        end
        OP_END: begin
          acc_re = cur_ok;
        end
        default: begin
          tr_re = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tr_we) begin
      tr_mem[tr_waddr] <= tr_wdata;
    end
    if (tr_re) begin
      tr_rdata <= tr_mem[tr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (acc_re) begin
      acc_rdata <= acc_mem[acc_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_cnt   <= '0;
      cur       <= '0;
      failed    <= 1'b0;
      fail_byte <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        BK_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == TR_AW'(TR_DEPTH - 1)) begin
            state <= BK_IDLE;
          end
        end
        BK_IDLE: begin
          if (take && (q_entry.op == OP_SYMBOL) && !failed) begin
            if (!q_entry.sym_ok) begin
              failed    <= 1'b1;
              fail_byte <= q_entry.char_code;
            end else if (cur_ok) begin
              state <= BK_STEP;
            end
          end else if (take && (q_entry.op == OP_END)) begin
            state <= BK_VERDICT;
          end
        end
        BK_STEP: begin
          // missing transition keeps the state
          if (tr_rdata[STATE_W]) begin
            cur <= tr_rdata[STATE_W-1:0];
          end
          state <= BK_IDLE;
        end
        BK_VERDICT: begin
          out_valid <= 1'b1;
          cur       <= cfg.start;
          failed    <= 1'b0;
          fail_byte <= '0;
          state     <= BK_IDLE;
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
      if (cfg.wr) begin
        cur       <= cfg.wr_value;
        failed    <= 1'b0;
        fail_byte <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_VERDICT) begin
      if (failed) begin
        verdict <= VERDICT_BAD_CHAR;
      end else if (cur_ok && acc_rdata) begin
        verdict <= VERDICT_ACCEPT;
      end else begin
        verdict <= VERDICT_REJECT;
      end
      bad_char    <= failed ? fail_byte : '0;
      final_state <= cur;
    end
  end

endmodule

[rtl/table_driven_dfa_recognizer.sv]
// top level of the table-driven dfa word recognizer
//
//   channel  direction  handshake            payload
//   in       request    in_valid/in_ready    command state_sel letter_sel target_state
//                                            target_valid accept_flag char_code
//   out      result     out_valid/out_ready  verdict bad_char final_state
//   config   apb        psel/penable/pready  start_state at byte address 0
//
// the front takes one request a cycle while in_ready is high; letter loads finish
//   there, transition and accepting loads as the back end takes them, and symbol steps
//   and end-of-word after a step or verdict state: the transition table and accepting
//   map are synchronous memories read with the current state, and the next symbol's
//   address needs that state; symbols after a failure or on an unmapped byte stay idle
// after reset the back end sweeps all NUM_STATES*NUM_LETTERS entries (1024 by default)
//   of the transition table and the accepting map, with in_ready low
// a four-entry queue between front and back lets the front keep taking
//   requests while the back waits on the result channel
`timescale 1ns / 1ps

module table_driven_dfa_recognizer #(
  parameter int NUM_STATES  = tdr_pkg::NUM_STATES_DEF,
  parameter int NUM_LETTERS = tdr_pkg::NUM_LETTERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tdr_pkg::CMD_W-1:0]      command,
  input  logic [tdr_pkg::STATE_W-1:0]    state_sel,
  input  logic [tdr_pkg::LETTER_W-1:0]   letter_sel,
  input  logic [tdr_pkg::STATE_W-1:0]    target_state,
  input  logic                           target_valid,
  input  logic                           accept_flag,
  input  logic [tdr_pkg::BYTE_W-1:0]     char_code,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tdr_pkg::VERDICT_W-1:0]  verdict,
  output logic [tdr_pkg::BYTE_W-1:0]     bad_char,
  output logic [tdr_pkg::STATE_W-1:0]    final_state,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tdr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tdr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tdr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import tdr_pkg::*;

  logic               start_state;
  logic [STATE_W-1:0] start_reg;
  logic               reg_hit;
  logic               cfg_wr;
  cfg_t               cfg;
  logic               clearing;
  logic               f_push;
  q_entry_t           f_entry;
  logic               q_ready;
  logic               q_pop;
  logic               q_valid;
  q_entry_t           q_entry;

  // word index of the access, bits below are the byte offset
  assign reg_hit     = paddr[APB_ADDR_W-1:2] == REG_START_STATE;
  assign start_state = reg_hit;
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready && start_state;
  assign prdata      = reg_hit ? APB_DATA_W'(start_reg) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_reg <= '0;
    end else if (cfg_wr) begin
      start_reg <= pwdata[STATE_W-1:0];
    end
  end

  // writing the start state also abandons the word in progress
  assign cfg.wr       = cfg_wr;
  assign cfg.wr_value = pwdata[STATE_W-1:0];
  assign cfg.start    = start_reg;

  // front: byte-to-letter map and request filtering
  tdr_front #(
    .NUM_STATES  (NUM_STATES),
    .NUM_LETTERS (NUM_LETTERS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .state_sel    (state_sel),
    .letter_sel   (letter_sel),
    .target_state (target_state),
    .target_valid (target_valid),
    .accept_flag  (accept_flag),
    .char_code    (char_code),
    .clearing     (clearing),
    .q_push       (f_push),
    .q_entry      (f_entry),
    .q_ready      (q_ready)
  );

  tdr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_entry (f_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  // back: automaton stepping, verdict and result register
  tdr_back #(
    .NUM_STATES  (NUM_STATES),
    .NUM_LETTERS (NUM_LETTERS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .verdict     (verdict),
    .bad_char    (bad_char),
    .final_state (final_state)
  );

endmodule

[tb/dfa_verdict_checker.sv]
// checker that tracks the loaded automaton and compares every verdict of the recognizer
`timescale 1ns / 1ps

module dfa_verdict_checker
  import tdr_pkg::*;
#(
  parameter logic [APB_ADDR_W-1:0] START_STATE_ADDR = '0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [STATE_W-1:0]    state_sel,
  input  logic [LETTER_W-1:0]   letter_sel,
  input  logic [STATE_W-1:0]    target_state,
  input  logic                  target_valid,
  input  logic                  accept_flag,
  input  logic [BYTE_W-1:0]     char_code,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [VERDICT_W-1:0]  verdict,
  input  logic [BYTE_W-1:0]     bad_char,
  input  logic [STATE_W-1:0]    final_state,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    error_count,
  output int                    verdicts_owed,
  output int                    verdicts_checked
);

  localparam int TABLE_SIZE = NUM_STATES_DEF * NUM_LETTERS_DEF;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [BYTE_W-1:0]    bad_char;
    logic [STATE_W-1:0]   final_state;
  } word_verdict_t;

  // top bit of each transition and letter entry marks it as present
  logic [STATE_W:0]   next_state_of [TABLE_SIZE];
  logic [LETTER_W:0]  letter_of [BYTE_VALUES];
  logic               accepting [NUM_STATES_DEF];
  logic [STATE_W-1:0] start_reg;
  logic [STATE_W-1:0] cur_state;
  logic               word_failed;
  logic [BYTE_W-1:0]  failed_byte;

  word_verdict_t verdicts_due [$];
  int            mismatches = 0;
  int            checked = 0;

  task automatic restart_word();
    cur_state   = start_reg;
    word_failed = 1'b0;
    failed_byte = '0;
  endtask

  task automatic clear_automaton();
    foreach (next_state_of[i]) next_state_of[i] = '0;
    foreach (letter_of[i]) letter_of[i] = '0;
    foreach (accepting[i]) accepting[i] = 1'b0;
    start_reg = '0;
    restart_word();
  endtask

  task automatic take_request();
    logic [LETTER_W:0] entry;
    logic [STATE_W:0]  move;
    word_verdict_t     v;
    case (command)
      CMD_LOAD_TRANS:
        if (int'(state_sel) < NUM_STATES_DEF && int'(letter_sel) < NUM_LETTERS_DEF)
          next_state_of[int'(state_sel) * NUM_LETTERS_DEF + int'(letter_sel)] =
            {target_valid, target_state};
      CMD_LOAD_LETTER:
        // the first letter given for a byte stays
        if (int'(letter_sel) < NUM_LETTERS_DEF && !letter_of[char_code][LETTER_W])
          letter_of[char_code] = {1'b1, letter_sel};
      CMD_SET_ACCEPT:
        if (int'(state_sel) < NUM_STATES_DEF) accepting[state_sel] = accept_flag;
      CMD_SYMBOL:
        if (!word_failed) begin
          entry = letter_of[char_code];
          if (!entry[LETTER_W]) begin
            word_failed = 1'b1;
            failed_byte = char_code;
          end else if (int'(cur_state) < NUM_STATES_DEF) begin
            move = next_state_of[int'(cur_state) * NUM_LETTERS_DEF
                                 + int'(entry[LETTER_W-1:0])];
            if (move[STATE_W]) cur_state = move[STATE_W-1:0];
          end
        end
      CMD_END_WORD: begin
        if (word_failed) v.verdict = VERDICT_BAD_CHAR;
        else if (int'(cur_state) < NUM_STATES_DEF && accepting[cur_state])
          v.verdict = VERDICT_ACCEPT;
        else v.verdict = VERDICT_REJECT;
        v.bad_char    = word_failed ? failed_byte : '0;
        v.final_state = cur_state;
        verdicts_due  = {verdicts_due, v};
        restart_word();
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    word_verdict_t oldest;
    if (rst) begin
      clear_automaton();
      verdicts_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none owed, verdict %0d bad_char %0d final_state %0d",
                   $time, verdict, bad_char, final_state);
        end else begin
          oldest = verdicts_due.pop_front();
          check_field("verdict", 32'(oldest.verdict), 32'(verdict));
          check_field("bad_char", 32'(oldest.bad_char), 32'(bad_char));
          check_field("final_state", 32'(oldest.final_state), 32'(final_state));
          checked++;
        end
      end
      if (psel && penable && pready && paddr == START_STATE_ADDR) begin
        if (pwrite) begin
          // a new start state abandons the word in progress
          start_reg = pwdata[STATE_W-1:0];
          restart_word();
        end else begin
          check_field("start_state readback", APB_DATA_W'(start_reg), prdata);
        end
      end
      if (in_valid && in_ready) take_request();
    end
    error_count      <= mismatches;
    verdicts_owed    <= verdicts_due.size();
    verdicts_checked <= checked;
  end

endmodule

[tb/table_driven_dfa_recognizer_tb.sv]
// testbench top: request and register stimulus, result-side stalls and the verdict
`timescale 1ns / 1ps

module table_driven_dfa_recognizer_tb;
  import tdr_pkg::*;

  // register 0 sits at byte address 0
  localparam logic [APB_ADDR_W-1:0] START_STATE_ADDR = APB_ADDR_W'(4 * REG_START_STATE);

  // commands the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam logic [STATE_W-1:0] LAST_STATE = STATE_W'(NUM_STATES_DEF - 1);

  localparam int RESET_CYCLES      = 10;
  localparam int SETTLE_CYCLES     = 24;     // queue plus back end, with margin
  localparam int LONG_HOLD_CYCLES  = 300;
  localparam int PHASE_REQUESTS    = 110;
  localparam int PRESSURE_REQUESTS = 40;
  localparam int CYCLE_LIMIT       = 100000;

  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [STATE_W-1:0]  state_sel;
    logic [LETTER_W-1:0] letter_sel;
    logic [STATE_W-1:0]  target_state;
    logic                target_valid;
    logic                accept_flag;
    logic [BYTE_W-1:0]   char_code;
  } recognizer_request_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  // request channel
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      command = CMD_LOAD_TRANS;
  logic [STATE_W-1:0]    state_sel = '0;
  logic [LETTER_W-1:0]   letter_sel = '0;
  logic [STATE_W-1:0]    target_state = '0;
  logic                  target_valid = 1'b0;
  logic                  accept_flag = 1'b0;
  logic [BYTE_W-1:0]     char_code = '0;
  // result channel
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VERDICT_W-1:0]  verdict;
  logic [BYTE_W-1:0]     bad_char;
  logic [STATE_W-1:0]    final_state;
  // register port
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // from the checker
  int error_count;
  int verdicts_owed;
  int verdicts_checked;

  // stimulus bookkeeping
  int idle_pct = 0;            // chance of a sender gap cycle before each request
  int stall_pct = 0;           // chance of out_ready low in a cycle
  int hold_requests = 0;       // bumped by the stimulus to ask for one long hold-off
  int holds_served = 0;
  int requests_sent = 0;
  int start_writes = 0;
  int cycle_count = 0;
  logic [BYTE_W-1:0] known_bytes [$];   // bytes that have been given a letter

  // all ports share their names with the block and the checker
  table_driven_dfa_recognizer u_top (.*);

  dfa_verdict_checker #(.START_STATE_ADDR(START_STATE_ADDR)) u_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit, far above the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off counted here when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // every field random, callers then fix what the command needs
  function automatic recognizer_request_t random_request();
    recognizer_request_t r;
    r.command      = CMD_W'($urandom_range(CMD_LOAD_TRANS, CMD_END_WORD));
    r.state_sel    = STATE_W'($urandom);
    r.letter_sel   = LETTER_W'($urandom);
    r.target_state = STATE_W'($urandom);
    r.target_valid = 1'($urandom);
    r.accept_flag  = 1'($urandom);
    r.char_code    = BYTE_W'($urandom);
    return r;
  endfunction

  // mostly a small set of states at both ends, so that words travel far
  function automatic logic [STATE_W-1:0] pick_state();
    if ($urandom_range(99) < 20) return STATE_W'($urandom);
    if ($urandom_range(1) == 0) return STATE_W'($urandom_range(0, 7));
    return LAST_STATE - STATE_W'($urandom_range(0, 7));
  endfunction

  // mostly bytes that have a letter, sometimes any byte
  function automatic logic [BYTE_W-1:0] pick_symbol_byte();
    if (known_bytes.size() != 0 && $urandom_range(99) < 88)
      return known_bytes[$urandom_range(0, known_bytes.size() - 1)];
    return BYTE_W'($urandom);
  endfunction

  // one request: optional gap cycles, then hold valid until it is taken
  task automatic send_request(input recognizer_request_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= r.command;
    state_sel    <= r.state_sel;
    letter_sel   <= r.letter_sel;
    target_state <= r.target_state;
    target_valid <= r.target_valid;
    accept_flag  <= r.accept_flag;
    char_code    <= r.char_code;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic load_transition(input logic [STATE_W-1:0] from_state,
                                 input logic [LETTER_W-1:0] letter,
                                 input logic [STATE_W-1:0] to_state, input logic present);
    recognizer_request_t r;
    r              = random_request();
    r.command      = CMD_LOAD_TRANS;
    r.state_sel    = from_state;
    r.letter_sel   = letter;
    r.target_state = to_state;
    r.target_valid = present;
    send_request(r);
  endtask

  task automatic load_letter(input logic [BYTE_W-1:0] code, input logic [LETTER_W-1:0] letter);
    recognizer_request_t r;
    r            = random_request();
    r.command    = CMD_LOAD_LETTER;
    r.char_code  = code;
    r.letter_sel = letter;
    known_bytes  = {known_bytes, code};
    send_request(r);
  endtask

  task automatic mark_accepting(input logic [STATE_W-1:0] which, input logic flag);
    recognizer_request_t r;
    r             = random_request();
    r.command     = CMD_SET_ACCEPT;
    r.state_sel   = which;
    r.accept_flag = flag;
    send_request(r);
  endtask

  task automatic send_symbol(input logic [BYTE_W-1:0] code);
    recognizer_request_t r;
    r           = random_request();
    r.command   = CMD_SYMBOL;
    r.char_code = code;
    send_request(r);
  endtask

  task automatic send_end_word();
    recognizer_request_t r;
    r         = random_request();
    r.command = CMD_END_WORD;
    send_request(r);
  endtask

  task automatic send_spare_command(input logic [CMD_W-1:0] code);
    recognizer_request_t r;
    r         = random_request();
    r.command = code;
    send_request(r);
  endtask

  // a word: symbols then its end, length zero included
  task automatic send_word(input int len);
    for (int i = 0; i < len; i++) send_symbol(pick_symbol_byte());
    send_end_word();
  endtask

  task automatic send_table_update();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4:
        load_transition(pick_state(), LETTER_W'($urandom), pick_state(),
                        $urandom_range(99) < 80);
      5, 6:    load_letter(BYTE_W'($urandom), LETTER_W'($urandom));
      7, 8:    mark_accepting(pick_state(), 1'($urandom));
      default: send_spare_command(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)));
    endcase
  endtask

  // stop offering, wait for every owed verdict, then let trailing loads finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdicts_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write with random upper bits, then a read back
  task automatic write_start_state(input logic [STATE_W-1:0] value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom;
    word[STATE_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= START_STATE_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read setup follows straight on
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    start_writes++;
    @(posedge clk);
  endtask

  // one phase: a burst of table loads, then words with loads and noise between
  task automatic run_phase(input int gap_pct, input int stall_chance);
    int first;
    idle_pct  = gap_pct;
    stall_pct = stall_chance;
    first     = requests_sent;
    repeat (12) send_table_update();
    while (requests_sent - first < PHASE_REQUESTS) begin
      if ($urandom_range(99) < 25) send_table_update();
      else send_word($urandom_range(0, 6));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    // the block clears its tables after reset with in_ready low
    do @(posedge clk); while (!in_ready);
    write_start_state(LAST_STATE);

    // directed: extremes of every field, every command, the corner behaviors
    load_letter(8'h00, 4'd0);
    load_letter(8'hFF, 4'd15);
    load_letter(8'h00, 4'd5);                        // byte already mapped, must be ignored
    load_letter(8'h41, 4'd3);
    load_transition(LAST_STATE, 4'd3, 6'd5, 1'b1);
    load_transition(LAST_STATE, 4'd3, 6'd5, 1'b0);   // removed again: letter 3 keeps state
    load_transition(LAST_STATE, 4'd15, 6'd0, 1'b1);
    load_transition(6'd0, 4'd0, LAST_STATE, 1'b1);
    mark_accepting(LAST_STATE, 1'b1);
    send_end_word();                                 // empty word in an accepting start
    send_symbol(8'h41);                              // no transition, stays
    send_symbol(8'hFF);
    send_symbol(8'h00);                              // only right if the first letter won
    send_end_word();
    send_symbol(8'hFF);
    send_symbol(8'h7E);                              // not in the alphabet
    send_symbol(8'h00);                              // after the failure, ignored
    send_symbol(8'h13);                              // second bad byte must not replace the first
    send_end_word();
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) send_spare_command(CMD_W'(c));
    mark_accepting(6'd0, 1'b1);
    mark_accepting(LAST_STATE, 1'b0);
    // a failed word abandoned by a start-state write ends clean in the new start
    send_symbol(8'hFF);
    send_symbol(8'h7E);
    settle();
    write_start_state(6'd5);
    send_end_word();

    // random phases, each from a fresh start state
    settle();
    write_start_state('0);
    run_phase(0, 0);
    settle();
    write_start_state(pick_state());
    run_phase(45, 0);
    settle();
    write_start_state(LAST_STATE);
    run_phase(0, 45);
    settle();
    write_start_state(STATE_W'($urandom));
    run_phase(28, 28);

    // back-pressure: result side held off while short words keep coming
    idle_pct = 0;
    hold_requests++;
    repeat (PRESSURE_REQUESTS) send_word($urandom_range(0, 2));
    settle();

    $display("run covered %0d requests over %0d start-state settings", requests_sent,
             start_writes);
    $display("%0d verdicts checked, through gaps, stalls and a long result hold-off",
             verdicts_checked);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[table_driven_dfa_recognizer.f]
rtl/tdr_pkg.sv
rtl/tdr_front.sv
rtl/tdr_queue.sv
rtl/tdr_back.sv
rtl/table_driven_dfa_recognizer.sv
tb/dfa_verdict_checker.sv
tb/table_driven_dfa_recognizer_tb.sv
